### rtl/psvm_pkg.sv
// shared types, constants and widths for the positional stereo voice mixer
// used by psvm_lane, psvm_datapath, psvm_ctrl and the top level
package psvm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 8;
  localparam int MV_W     = 7;
  localparam int DIST_W   = 16;
  localparam int ACC_W    = 32;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int FACT_W   = 17;   // 30 - |dx|, down to 30 - 32768
  localparam int FALL_W   = 5;    // 30 - distance, 0..30
  localparam int GAIN_W   = 20;   // scaled gain, about +-278k
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;

  localparam logic [FALL_W-1:0] FALLOFF_RANGE = 5'd30;
  localparam logic [MV_W-1:0]   MV_RESET      = 7'd100;

  // divide by 30: floor(x * RECIP30 >> 28), exact for x below 2^24
  localparam logic [23:0] RECIP30       = 24'd8947849;
  localparam int          RECIP30_SHIFT = 28;
  // divide by 101: floor(x * RECIP101 >> 37), exact for x up to 2^30
  localparam logic [30:0] RECIP101       = 31'd1360781718;
  localparam int          RECIP101_SHIFT = 37;
  // any magnitude beyond this clamps anyway after /101 and >>8
  localparam logic [38:0] SAT_MAG       = 39'd1073741824;
  localparam logic [14:0] OUT_LIMIT     = 15'h7fff;
  localparam int          OUT_SHIFT     = 8;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_GAIN1,
    OP_DIV1,
    OP_GAIN2,
    OP_DIV2,
    OP_SCALE,
    OP_ACC,
    OP_MASTER,
    OP_DIV101
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN1,
    S_DIV1,
    S_GAIN2,
    S_DIV2,
    S_SCALE,
    S_ACC,
    S_MASTER,
    S_DIV101,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    op_t  op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } sts_t;

endpackage

### rtl/positional_stereo_voice_mixer.sv
// positional stereo voice mixer: a voice item is accepted in idle, then takes six lane
// steps before the next transfer is taken; an item marked last adds master, divide and
// emit steps, and emit waits while the output register is busy; each side has one
// multiplier that does five products per voice and two per frame
// reset: accumulators cleared, master volume 100, output register empty
// top level, depends on psvm_pkg, psvm_ctrl and psvm_datapath
module positional_stereo_voice_mixer (
  input  logic                                 clk,
  input  logic                                 rst,
  // input voice stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_left[15:0], sample_right[31:16], voice_volume[39:32],
  // dx_offset[55:40], distance[71:56]
  input  logic [psvm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // mono[0], positional[1], sample_valid[2]
  input  logic [psvm_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  // last_voice
  input  logic                                 s_axis_tlast,
  // mixed frame stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // left_out[15:0], right_out[31:16]
  output logic [psvm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // master volume register, written whenever cfg_wr_en is high
  input  logic                                 cfg_wr_en,
  input  logic [psvm_pkg::MV_W-1:0]            cfg_wr_data
);

  psvm_pkg::cmd_t                       cmd;
  psvm_pkg::sts_t                       sts;
  logic signed [psvm_pkg::SAMPLE_W-1:0] left_out;
  logic signed [psvm_pkg::SAMPLE_W-1:0] right_out;

  // controller walks the per-voice steps; a voice transfer happens only in idle
  psvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath unpacks the stream fields directly from tdata and tuser
  psvm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .sample_left  (s_axis_tdata[15:0]),
    .sample_right (s_axis_tdata[31:16]),
    .mono         (s_axis_tuser[0]),
    .voice_volume (s_axis_tdata[39:32]),
    .positional   (s_axis_tuser[1]),
    .dx_offset    (s_axis_tdata[55:40]),
    .distance     (s_axis_tdata[71:56]),
    .sample_valid (s_axis_tuser[2]),
    .last_voice   (s_axis_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .left_out     (left_out),
    .right_out    (right_out)
  );

  // the output register keeps a finished frame while new voices keep arriving
  assign m_axis_tdata = {right_out, left_out};

endmodule

### rtl/psvm_lane.sv
// one output side: gain scaling, accumulation and frame finish on a shared multiplier
// depends on psvm_pkg
module psvm_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  psvm_pkg::op_t                         op,
  input  logic                                  emit,
  input  logic signed [psvm_pkg::FACT_W-1:0]    factor,
  input  logic [psvm_pkg::VOL_W-1:0]            vol,
  input  logic [psvm_pkg::FALL_W-1:0]           fall,
  input  logic signed [psvm_pkg::SAMPLE_W-1:0]  sample,
  input  logic [psvm_pkg::MV_W-1:0]             mv,
  output logic signed [psvm_pkg::SAMPLE_W-1:0]  result
);

  logic signed [psvm_pkg::PROD_W-1:0] prod;
  logic                               neg;
  logic signed [psvm_pkg::ACC_W-1:0]  acc;

  logic signed [psvm_pkg::MUL_W-1:0]  mul_a;
  logic signed [psvm_pkg::MUL_W-1:0]  mul_b;
  logic signed [24:0]                 p_small;
  logic [24:0]                        p_mag;
  logic [18:0]                        q30;
  logic signed [psvm_pkg::GAIN_W-1:0] gain;
  logic signed [38:0]                 x;
  logic [38:0]                        x_mag;
  logic [30:0]                        x_sat;
  logic [23:0]                        q101;
  logic [24:0]                        rnd;
  logic [16:0]                        shifted;
  logic [14:0]                        mag;

  always_comb begin
    p_small = prod[24:0];
    p_mag   = p_small[24] ? 25'(-p_small) : 25'(p_small);
    q30     = prod[psvm_pkg::RECIP30_SHIFT+18:psvm_pkg::RECIP30_SHIFT];
    gain    = neg ? -$signed({1'b0, q30}) : $signed({1'b0, q30});

    x       = prod[38:0];
    x_mag   = x[38] ? 39'(-x) : 39'(x);
    x_sat   = (x_mag > psvm_pkg::SAT_MAG) ? psvm_pkg::SAT_MAG[30:0] : x_mag[30:0];

    // truncate toward zero, then >>8 rounding down: ceil on the magnitude if negative
    q101    = prod[psvm_pkg::RECIP101_SHIFT+23:psvm_pkg::RECIP101_SHIFT];
    rnd     = {1'b0, q101} + (neg ? 25'd255 : 25'd0);
    shifted = rnd[24:psvm_pkg::OUT_SHIFT];
    mag     = (shifted > {2'b00, psvm_pkg::OUT_LIMIT}) ? psvm_pkg::OUT_LIMIT : shifted[14:0];
    result  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // operand selection for the one multiplier of this side
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      psvm_pkg::OP_GAIN1: begin
        mul_a = {{(psvm_pkg::MUL_W-psvm_pkg::FACT_W){factor[psvm_pkg::FACT_W-1]}}, factor};
        mul_b = {{(psvm_pkg::MUL_W-psvm_pkg::VOL_W){1'b0}}, vol};
      end
      psvm_pkg::OP_DIV1, psvm_pkg::OP_DIV2: begin
        mul_a = {7'd0, p_mag};
        mul_b = {8'd0, psvm_pkg::RECIP30};
      end
      psvm_pkg::OP_GAIN2: begin
        mul_a = {{(psvm_pkg::MUL_W-psvm_pkg::GAIN_W){gain[psvm_pkg::GAIN_W-1]}}, gain};
        mul_b = {{(psvm_pkg::MUL_W-psvm_pkg::FALL_W){1'b0}}, fall};
      end
      psvm_pkg::OP_SCALE: begin
        mul_a = {{(psvm_pkg::MUL_W-psvm_pkg::GAIN_W){gain[psvm_pkg::GAIN_W-1]}}, gain};
        mul_b = {{(psvm_pkg::MUL_W-psvm_pkg::SAMPLE_W){sample[psvm_pkg::SAMPLE_W-1]}}, sample};
      end
      psvm_pkg::OP_MASTER: begin
        mul_a = acc;
        mul_b = {{(psvm_pkg::MUL_W-psvm_pkg::MV_W){1'b0}}, mv};
      end
      psvm_pkg::OP_DIV101: begin
        mul_a = {1'b0, x_sat};
        mul_b = {1'b0, psvm_pkg::RECIP101};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (op)
      psvm_pkg::OP_GAIN1, psvm_pkg::OP_GAIN2, psvm_pkg::OP_SCALE,
      psvm_pkg::OP_MASTER: begin
        prod <= mul_a * mul_b;
      end
      psvm_pkg::OP_DIV1, psvm_pkg::OP_DIV2: begin
        prod <= mul_a * mul_b;
        neg  <= p_small[24];
      end
      psvm_pkg::OP_DIV101: begin
        prod <= mul_a * mul_b;
        neg  <= x[38];
      end
      default: begin
      end
    endcase
  end

  // accumulator wraps modulo 2^32
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (emit) begin
      acc <= '0;
    end else if (op == psvm_pkg::OP_ACC) begin
      acc <= acc + prod[psvm_pkg::ACC_W-1:0];
    end
  end

endmodule

### rtl/psvm_datapath.sv
// datapath: input capture, gain factors, master volume, two side lanes, output register
// depends on psvm_pkg and psvm_lane
module psvm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  psvm_pkg::cmd_t                        cmd,
  output psvm_pkg::sts_t                        sts,
  input  logic signed [psvm_pkg::SAMPLE_W-1:0]  sample_left,
  input  logic signed [psvm_pkg::SAMPLE_W-1:0]  sample_right,
  input  logic                                  mono,
  input  logic [psvm_pkg::VOL_W-1:0]            voice_volume,
  input  logic                                  positional,
  input  logic signed [psvm_pkg::SAMPLE_W-1:0]  dx_offset,
  input  logic [psvm_pkg::DIST_W-1:0]           distance,
  input  logic                                  sample_valid,
  input  logic                                  last_voice,
  input  logic                                  cfg_wr_en,
  input  logic [psvm_pkg::MV_W-1:0]             cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [psvm_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [psvm_pkg::SAMPLE_W-1:0]  right_out
);

  logic [psvm_pkg::MV_W-1:0]            master_volume;
  logic signed [psvm_pkg::FACT_W-1:0]   factor_l;
  logic signed [psvm_pkg::FACT_W-1:0]   factor_r;
  logic [psvm_pkg::VOL_W-1:0]           vol;
  logic [psvm_pkg::FALL_W-1:0]          fall;
  logic signed [psvm_pkg::SAMPLE_W-1:0] smp_l;
  logic signed [psvm_pkg::SAMPLE_W-1:0] smp_r;
  logic                                 last;

  logic signed [psvm_pkg::FACT_W-1:0]   dx_ext;
  logic signed [psvm_pkg::FACT_W-1:0]   adx;
  logic signed [psvm_pkg::FACT_W-1:0]   pan;
  logic signed [psvm_pkg::FACT_W-1:0]   range_ext;
  logic                                 dx_pos;
  logic [psvm_pkg::FALL_W-1:0]          fall_next;
  logic signed [psvm_pkg::SAMPLE_W-1:0] res_l;
  logic signed [psvm_pkg::SAMPLE_W-1:0] res_r;

  // a side that is not panned scales by 30/30, which leaves the gain unchanged
  always_comb begin
    dx_ext    = {dx_offset[psvm_pkg::SAMPLE_W-1], dx_offset};
    adx       = dx_ext[psvm_pkg::FACT_W-1] ? -dx_ext : dx_ext;
    range_ext = $signed({{(psvm_pkg::FACT_W-psvm_pkg::FALL_W){1'b0}},
                         psvm_pkg::FALLOFF_RANGE});
    pan       = range_ext - adx;
    dx_pos    = !dx_offset[psvm_pkg::SAMPLE_W-1] && (dx_offset != '0);
    if (!sample_valid) begin
      fall_next = '0;
    end else if (!positional) begin
      fall_next = psvm_pkg::FALLOFF_RANGE;
    end else if (distance < {{(psvm_pkg::DIST_W-psvm_pkg::FALL_W){1'b0}},
                             psvm_pkg::FALLOFF_RANGE}) begin
      fall_next = psvm_pkg::FALLOFF_RANGE - distance[psvm_pkg::FALL_W-1:0];
    end else begin
      fall_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      factor_l <= (positional && dx_pos) ? pan : range_ext;
      factor_r <= (positional && !dx_pos) ? pan : range_ext;
      vol      <= voice_volume;
      fall     <= fall_next;
      smp_l    <= sample_left;
      smp_r    <= mono ? sample_left : sample_right;
      last     <= last_voice;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= psvm_pkg::MV_RESET;
    end else if (cfg_wr_en) begin
      master_volume <= cfg_wr_data;
    end
  end

  psvm_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .op     (cmd.op),
    .emit   (cmd.emit),
    .factor (factor_l),
    .vol    (vol),
    .fall   (fall),
    .sample (smp_l),
    .mv     (master_volume),
    .result (res_l)
  );

  psvm_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .op     (cmd.op),
    .emit   (cmd.emit),
    .factor (factor_r),
    .vol    (vol),
    .fall   (fall),
    .sample (smp_r),
    .mv     (master_volume),
    .result (res_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      left_out  <= res_l;
      right_out <= res_r;
    end
  end

  assign sts.last     = last;
  assign sts.out_busy = out_valid && !out_ready;

endmodule

### rtl/psvm_ctrl.sv
// controller: steps each item through the lane operations and closes frames
// depends on psvm_pkg
module psvm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output psvm_pkg::cmd_t cmd,
  input  psvm_pkg::sts_t sts
);

  psvm_pkg::state_t state;
  psvm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psvm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = psvm_pkg::OP_IDLE;
    cmd.emit   = 1'b0;
    case (state)
      psvm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = psvm_pkg::S_GAIN1;
        end
      end
      psvm_pkg::S_GAIN1: begin
        cmd.op     = psvm_pkg::OP_GAIN1;
        state_next = psvm_pkg::S_DIV1;
      end
      psvm_pkg::S_DIV1: begin
        cmd.op     = psvm_pkg::OP_DIV1;
        state_next = psvm_pkg::S_GAIN2;
      end
      psvm_pkg::S_GAIN2: begin
        cmd.op     = psvm_pkg::OP_GAIN2;
        state_next = psvm_pkg::S_DIV2;
      end
      psvm_pkg::S_DIV2: begin
        cmd.op     = psvm_pkg::OP_DIV2;
        state_next = psvm_pkg::S_SCALE;
      end
      psvm_pkg::S_SCALE: begin
        cmd.op     = psvm_pkg::OP_SCALE;
        state_next = psvm_pkg::S_ACC;
      end
      psvm_pkg::S_ACC: begin
        cmd.op     = psvm_pkg::OP_ACC;
        state_next = sts.last ? psvm_pkg::S_MASTER : psvm_pkg::S_IDLE;
      end
      psvm_pkg::S_MASTER: begin
        cmd.op     = psvm_pkg::OP_MASTER;
        state_next = psvm_pkg::S_DIV101;
      end
      psvm_pkg::S_DIV101: begin
        cmd.op     = psvm_pkg::OP_DIV101;
        state_next = psvm_pkg::S_EMIT;
      end
      psvm_pkg::S_EMIT: begin
        // hold the frame until the output register is free
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = psvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = psvm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### dv/positional_stereo_voice_mixer_tb.sv
// self-checking testbench for positional_stereo_voice_mixer: voice transfers in, mixed frames out
// a built-in predictor tracks the accumulators and master volume and checks every output frame
// depends on psvm_pkg and the positional_stereo_voice_mixer top level
module positional_stereo_voice_mixer_tb;

  // mixing constants of the block
  localparam longint FALL_SPAN   = 30;     // falloff and pan range
  localparam longint MV_DIVISOR  = 101;    // master volume divisor
  localparam longint CLAMP_MAX   = 32767;  // output magnitude limit
  localparam int     FRAME_SHIFT = 8;
  localparam int     FULL_FRAME  = 32;     // nominal voices per frame
  localparam int     SETTLE_CYC  = 24;     // covers the frame latency with margin
  localparam int     STALL_CYC   = 400;    // long receiver hold-off
  localparam int     STALL_AT    = 250;    // input transfer count that starts the hold-off
  localparam int     WATCHDOG    = 4000;   // cycles without any transfer before giving up
  localparam int     PHASE_ITEMS = 150;

  typedef struct {
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic               mono;
    logic [7:0]         volume;
    logic               positional;
    logic signed [15:0] dx;
    logic [15:0]        distance;
    logic               valid;
    logic               last;
  } voice_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [psvm_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
  logic [psvm_pkg::IN_TUSER_W-1:0]     s_axis_tuser  = '0;
  logic                                s_axis_tlast  = 1'b0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [psvm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
  logic                                cfg_wr_en     = 1'b0;
  logic [psvm_pkg::MV_W-1:0]           cfg_wr_data   = '0;

  // predictor state: accumulators and the master volume copy
  logic [31:0]               left_sum  = '0;
  logic [31:0]               right_sum = '0;
  logic [psvm_pkg::MV_W-1:0] master_vol = psvm_pkg::MV_RESET;

  voice_t pending_voices[$];     // items waiting for the driver
  frame_t mixed_frames_due[$];   // frames predicted but not yet seen

  int  fail_cnt     = 0;
  int  in_count     = 0;
  int  rx_hold_left = 0;
  bit  rx_held      = 1'b0;
  bit  idle_on      = 1'b1;
  int  quiet_cyc    = 0;

  positional_stereo_voice_mixer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scale one accumulator by master/101, floor shift by 8, clamp
  function automatic logic [15:0] scale_side(input logic [31:0] acc);
    longint sum;
    longint q;
    longint s;
    sum = longint'($signed(acc));
    q = (sum * longint'(master_vol)) / MV_DIVISOR;  // truncates toward zero
    s = q >>> FRAME_SHIFT;                          // rounds toward minus infinity
    if (s > CLAMP_MAX) s = CLAMP_MAX;
    else if (s < -CLAMP_MAX) s = -CLAMP_MAX;
    return s[15:0];
  endfunction

  // add one voice into the accumulators; returns 1 with the frame when it closes one
  function automatic bit mix_voice(input voice_t v, output frame_t f);
    longint sl;
    longint sr;
    longint lg;
    longint rg;
    longint dx;
    longint adx;
    longint dist_v;
    sl     = longint'(v.sample_left);
    sr     = longint'(v.sample_right);
    dx     = longint'(v.dx);
    dist_v = longint'(v.distance);
    f      = '{left: '0, right: '0};
    if (v.valid) begin
      lg = longint'(v.volume);
      rg = lg;
      if (v.mono) sr = sl;
      if (v.positional) begin
        if (dist_v < FALL_SPAN) begin
          adx = (dx < 0) ? -dx : dx;
          // pan the side away from the offset; may go negative past the range
          if (dx > 0) lg = ((FALL_SPAN - adx) * lg) / FALL_SPAN;
          else rg = ((FALL_SPAN - adx) * rg) / FALL_SPAN;
          lg = (lg * (FALL_SPAN - dist_v)) / FALL_SPAN;
          rg = (rg * (FALL_SPAN - dist_v)) / FALL_SPAN;
        end else begin
          lg = 0;
          rg = 0;
        end
      end
      // accumulators wrap modulo 2^32
      left_sum  = left_sum + 32'(sl * lg);
      right_sum = right_sum + 32'(sr * rg);
    end
    if (!v.last) return 1'b0;
    f.left    = scale_side(left_sum);
    f.right   = scale_side(right_sum);
    left_sum  = '0;
    right_sum = '0;
    return 1'b1;
  endfunction

  task automatic add_voice(input int sl, input int sr, input bit mono, input int vol,
                           input bit pos, input int dx, input int dist_v,
                           input bit valid, input bit last);
    voice_t v;
    v.sample_left  = 16'(sl);
    v.sample_right = 16'(sr);
    v.mono         = mono;
    v.volume       = 8'(vol);
    v.positional   = pos;
    v.dx           = 16'(dx);
    v.distance     = 16'(dist_v);
    v.valid        = valid;
    v.last         = last;
    pending_voices.push_back(v);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // random voice, weighted toward the interesting pan and falloff range
  function automatic voice_t rand_voice(input bit last);
    voice_t v;
    v.sample_left  = rand_sample();
    v.sample_right = rand_sample();
    v.mono         = ($urandom_range(0, 3) == 0);
    v.volume       = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hff : 8'h00)
                                                  : 8'($urandom);
    v.positional   = 1'($urandom_range(0, 1));
    v.dx           = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 80)) - 16'd40;
    v.distance     = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    v.valid        = ($urandom_range(0, 9) != 0);
    v.last         = last;
    return v;
  endfunction

  // whole frames of random voices, mostly short with the odd full-length one
  task automatic queue_random_frames(input int n);
    int count;
    int len;
    count = 0;
    while (count < n) begin
      len = ($urandom_range(0, 9) == 0) ? FULL_FRAME : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) pending_voices.push_back(rand_voice(i == len - 1));
      count += len;
    end
  endtask

  // sender holds off until every frame is out, then lets the datapath settle
  task automatic drain();
    while (pending_voices.size() != 0 || mixed_frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_master_volume(input int value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= psvm_pkg::MV_W'(value);
    master_vol  = psvm_pkg::MV_W'(value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("mismatch on %s: expected %0d, got %0d", what, $signed(want), $signed(got));
  endtask

  // input driver: predicts on each accepted transfer, then offers the next item
  always @(posedge clk) begin
    frame_t f;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (mix_voice(pending_voices[0], f)) mixed_frames_due.push_back(f);
        void'(pending_voices.pop_front());
        in_count++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // item still on offer, keep it steady
      end else if (pending_voices.size() != 0 && !(idle_on && $urandom_range(0, 99) < 8)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pending_voices[0].distance, pending_voices[0].dx,
                          pending_voices[0].volume, pending_voices[0].sample_right,
                          pending_voices[0].sample_left};
        s_axis_tuser  <= {pending_voices[0].valid, pending_voices[0].positional,
                          pending_voices[0].mono};
        s_axis_tlast  <= pending_voices[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output monitor: checks each frame transfer and paces tready
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mixed_frames_due.size() == 0) begin
          flag_mismatch("unexpected frame, left", '0, m_axis_tdata[15:0]);
        end else begin
          want = mixed_frames_due.pop_front();
          if (m_axis_tdata[15:0] !== want.left)
            flag_mismatch("left_out", want.left, m_axis_tdata[15:0]);
          if (m_axis_tdata[31:16] !== want.right)
            flag_mismatch("right_out", want.right, m_axis_tdata[31:16]);
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (!rx_held && in_count >= STALL_AT) begin
        rx_held      = 1'b1;
        rx_hold_left = STALL_CYC;
      end
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 8);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed voices at the reset master volume
    add_voice(32767, -32768, 0, 255, 0, 0, 0, 1, 0);
    add_voice(32767, -32768, 0, 255, 0, 0, 0, 1, 0);
    add_voice(32767, -32768, 0, 255, 0, 0, 0, 1, 1);       // both sides clamp
    add_voice(-32768, 12345, 1, 255, 0, 0, 0, 1, 1);       // mono copies left
    add_voice(1000, 2000, 0, 128, 1, 0, 0, 1, 0);          // zero offset pans right
    add_voice(-1000, 3000, 0, 200, 1, 12, 5, 1, 0);        // positive offset pans left
    add_voice(5000, -5000, 0, 200, 1, -12, 29, 1, 1);      // nearest edge of falloff
    add_voice(32767, 32767, 0, 255, 1, 3, 30, 1, 0);       // at falloff range, silent
    add_voice(32767, 32767, 0, 255, 1, 3, 65535, 1, 1);    // farthest distance
    add_voice(32767, -32768, 0, 255, 1, 32767, 0, 1, 0);   // offset past range, negative gain
    add_voice(-32768, -32768, 0, 255, 1, -32768, 0, 1, 1);
    add_voice(12345, -123, 0, 0, 0, 0, 0, 1, 1);           // zero voice volume
    add_voice(-1, -1, 1, 255, 1, -31, 0, 1, 1);
    add_voice(32767, 32767, 0, 255, 0, 0, 0, 0, 1);        // invalid item still closes frame
    add_voice(-32768, 32767, 1, 255, 1, 7, 7, 0, 0);       // invalid item adds nothing
    add_voice(100, 200, 0, 50, 0, 0, 0, 1, 1);
    // accumulator wrap with the largest negative gain
    add_voice(-32768, -32768, 0, 255, 1, -32768, 0, 1, 0);
    add_voice(-32768, -32768, 0, 255, 1, -32768, 0, 1, 0);
    add_voice(-32768, -32768, 0, 255, 1, -32768, 0, 1, 0);
    add_voice(-32768, -32768, 0, 255, 1, -32768, 0, 1, 1);
    drain();

    // random phases over several master volume settings
    write_master_volume(127);
    queue_random_frames(PHASE_ITEMS);
    drain();
    write_master_volume(101);                 // receiver hold-off lands in this phase
    queue_random_frames(PHASE_ITEMS);
    drain();
    write_master_volume(0);
    queue_random_frames(PHASE_ITEMS);
    drain();
    idle_on = 1'b0;                           // back-to-back stretch
    write_master_volume(1);
    queue_random_frames(PHASE_ITEMS);
    drain();
    idle_on = 1'b1;
    write_master_volume($urandom_range(2, 99));
    queue_random_frames(PHASE_ITEMS);
    drain();
    write_master_volume(100);
    queue_random_frames(PHASE_ITEMS);
    drain();

    if (mixed_frames_due.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
